// File: sv/xdp_pkg.sv
// ----------------------------------------------------------------------------
// xdp_pkg
// Types, codes and constants shared by the distance projection block.
// ----------------------------------------------------------------------------
package xdp_pkg;

  // Default particle count and index width of a request
  localparam int NUM_PARTICLES_DEF = 1024;
  localparam int PIDX_W            = 10;

  // Register map
  localparam logic        REG_TIME_STEP   = 1'b0;
  localparam logic [16:0] TIME_STEP_RESET = 17'd1092;

  // Request types
  localparam logic [1:0] REQ_WRITE   = 2'd0;
  localparam logic [1:0] REQ_PROJECT = 2'd1;
  localparam logic [1:0] REQ_READ    = 2'd2;
  localparam logic [1:0] REQ_UNKNOWN = 2'd3;

  // Status codes
  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_FIXED      = 2'd1;
  localparam logic [1:0] ST_COINCIDENT = 2'd2;
  localparam logic [1:0] ST_SAT        = 2'd3;

  // Shared unit operations
  localparam logic [1:0] ALU_MUL  = 2'd0;
  localparam logic [1:0] ALU_DIV  = 2'd1;
  localparam logic [1:0] ALU_SQRT = 2'd2;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [9:0]         particle_a;
    logic [9:0]         particle_b;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [31:0]        inverse_mass;
    logic [30:0]        rest_length;
    logic [31:0]        compliance;
  } req_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [31:0]        out_inverse_mass;
    logic [1:0]         status;
  } rsp_t;

  typedef struct packed {
    logic       start;
    logic [1:0] op;
  } alu_cmd_t;

endpackage

// File: sv/xdp_ram.sv
// ----------------------------------------------------------------------------
// xdp_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module xdp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write at addr, register read data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: sv/xdp_alu.sv
// ----------------------------------------------------------------------------
// xdp_alu
// Bit-serial multiply, restoring divide and integer square root on 64 bits.
// ----------------------------------------------------------------------------
module xdp_alu
  import xdp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  alu_cmd_t    cmd,
  input  logic [63:0] opa,
  input  logic [63:0] opb,
  output logic        done,
  output logic [63:0] result
);

  logic        busy, busy_next;
  logic [1:0]  op_r, op_next;
  logic [64:0] acc, acc_next;
  logic [63:0] q, q_next;
  logic [63:0] m, m_next;
  logic [6:0]  cnt, cnt_next;
  logic        done_next;
  logic [64:0] rem2;
  logic [63:0] root_try;

  assign rem2     = {acc[63:0], q[63]};
  assign root_try = q + m;

  // Load on start, then advance one step a cycle
  always_comb begin
    acc_next  = acc;
    q_next    = q;
    m_next    = m;
    cnt_next  = cnt;
    busy_next = busy;
    op_next   = op_r;
    done_next = 1'b0;
    if (cmd.start) begin
      busy_next = 1'b1;
      op_next   = cmd.op;
      unique case (cmd.op)
        ALU_DIV: begin
          acc_next = '0;
          q_next   = opa;
          m_next   = opb;
          cnt_next = 7'd64;
        end
        ALU_SQRT: begin
          acc_next = {1'b0, opa};
          q_next   = '0;
          m_next   = 64'd1 << 62;
          cnt_next = 7'd32;
        end
        default: begin
          acc_next = '0;
          q_next   = opb;
          m_next   = opa;
          cnt_next = '0;
        end
      endcase
    end else if (busy) begin
      unique case (op_r)
        ALU_DIV: begin
          if (rem2 >= {1'b0, m}) begin
            acc_next = rem2 - {1'b0, m};
            q_next   = {q[62:0], 1'b1};
          end else begin
            acc_next = rem2;
            q_next   = {q[62:0], 1'b0};
          end
          cnt_next = cnt - 7'd1;
          if (cnt == 7'd1) begin
            busy_next = 1'b0;
            done_next = 1'b1;
          end
        end
        ALU_SQRT: begin
          if (acc[63:0] >= root_try) begin
            acc_next = {1'b0, acc[63:0] - root_try};
            q_next   = (q >> 1) + m;
          end else begin
            q_next = q >> 1;
          end
          m_next   = m >> 2;
          cnt_next = cnt - 7'd1;
          if (cnt == 7'd1) begin
            busy_next = 1'b0;
            done_next = 1'b1;
          end
        end
        default: begin
          // Shift-add until the multiplier runs out of ones
          if (q == '0) begin
            busy_next = 1'b0;
            done_next = 1'b1;
          end else begin
            acc_next = {1'b0, acc[63:0] + (q[0] ? m : 64'd0)};
            m_next   = m << 1;
            q_next   = q >> 1;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= busy_next;
      done <= done_next;
    end
    op_r <= op_next;
    acc  <= acc_next;
    q    <= q_next;
    m    <= m_next;
    cnt  <= cnt_next;
  end

  assign result = (op_r == ALU_MUL) ? acc[63:0] : q;

endmodule

// File: sv/xpbd_distance_projection.sv
// ----------------------------------------------------------------------------
// xpbd_distance_projection
// Particle store with XPBD distance constraint projection in Q16.16.
// ----------------------------------------------------------------------------
// One request at a time; each result is held until an earlier result still
// waiting on out_stall has been taken. A full projection runs through one
// bit-serial unit that does a 64-step divide six times, a 32-step square root
// once and sixteen shift-add multiplies, each multiply ending once its
// multiplier runs out of ones. Particle memories are single-port RAMs with
// registered read; nothing is cleared at reset, so read only particles already
// written.
module xpbd_distance_projection
  import xdp_pkg::*;
#(
  parameter int NUM_PARTICLES = NUM_PARTICLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  req_t        in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output rsp_t        out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(NUM_PARTICLES);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_WR    = 5'd1;
  localparam logic [4:0] S_RDA   = 5'd2;
  localparam logic [4:0] S_RDB   = 5'd3;
  localparam logic [4:0] S_RDW   = 5'd4;
  localparam logic [4:0] S_CHK   = 5'd5;
  localparam logic [4:0] S_SQ    = 5'd6;
  localparam logic [4:0] S_SQRT  = 5'd7;
  localparam logic [4:0] S_TS    = 5'd8;
  localparam logic [4:0] S_ALPHA = 5'd9;
  localparam logic [4:0] S_F0    = 5'd10;
  localparam logic [4:0] S_F1    = 5'd11;
  localparam logic [4:0] S_U     = 5'd12;
  localparam logic [4:0] S_E0A   = 5'd13;
  localparam logic [4:0] S_E0B   = 5'd14;
  localparam logic [4:0] S_E1A   = 5'd15;
  localparam logic [4:0] S_E1B   = 5'd16;
  localparam logic [4:0] S_WA    = 5'd17;
  localparam logic [4:0] S_WB    = 5'd18;
  localparam logic [4:0] S_OUT   = 5'd19;

  logic [4:0]  state;
  logic [16:0] time_step;
  req_t        rq;
  logic [AW-1:0] ia, ib;
  rsp_t        res;

  logic signed [34:0] pa [3];
  logic signed [34:0] pb [3];
  logic [31:0] w0, w1;
  logic [32:0] nm [3];
  logic        n_neg [3];
  logic        shift;
  logic [1:0]  ax;
  logic [63:0] sum;
  logic [32:0] d;
  logic [33:0] ts2;
  logic [63:0] den;
  logic [30:0] f0, f1;
  logic [32:0] drm;
  logic        drneg;
  logic [30:0] u;
  logic [33:0] t;
  logic        issued;

  // Combinational helpers
  logic signed [34:0] ndiff [3];
  logic [32:0] nm_c [3];
  logic        shift_c;
  logic [32:0] ws;
  logic [64:0] den_sum;
  logic [16:0] ts_eff;
  logic [31:0] h_cur;
  logic [33:0] e_cur;
  logic        neg_cur;
  logic        is_comp;
  logic        any_sat;

  alu_cmd_t    alu_cmd;
  logic [63:0] alu_a, alu_b, alu_res;
  logic        alu_done;

  logic [AW-1:0] mem_addr;
  logic        we_pos, we_im;
  logic [31:0] wr_x, wr_y, wr_z;
  logic [31:0] rd_x, rd_y, rd_z, rd_im;

  // Reduce a request index modulo the particle count, one bit a step
  function automatic logic [AW-1:0] idx_mod(input logic [PIDX_W-1:0] v);
    logic [PIDX_W:0] r;
    r = '0;
    for (int i = PIDX_W - 1; i >= 0; i--) begin
      r = {r[PIDX_W-1:0], v[i]};
      if (32'(r) >= NUM_PARTICLES) begin
        r = r - (PIDX_W + 1)'(NUM_PARTICLES);
      end
    end
    return AW'(r);
  endfunction

  function automatic logic [31:0] clamp_pos(input logic signed [34:0] v);
    if (v > 35'sh0_7FFF_FFFF) begin
      return 32'h7FFF_FFFF;
    end else if (v < -35'sh0_8000_0000) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic pos_sat(input logic signed [34:0] v);
    return (v > 35'sh0_7FFF_FFFF) || (v < -35'sh0_8000_0000);
  endfunction

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TIME_STEP) ? {15'd0, time_step} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step <= TIME_STEP_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_TIME_STEP) begin
      time_step <= pwdata[16:0];
    end
  end

  // Spring vector and derived values
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ndiff[i] = pb[i] - pa[i];
      nm_c[i]  = ndiff[i][34] ? 33'(-ndiff[i]) : ndiff[i][32:0];
    end
    shift_c = (|nm_c[0][32:31]) || (|nm_c[1][32:31]) || (|nm_c[2][32:31]);
  end

  assign ws      = 33'(w0) + 33'(w1);
  assign den_sum = 65'(ws) + 65'(alu_res);
  assign ts_eff  = (time_step == '0) ? 17'd1 : time_step;
  assign h_cur   = 32'(nm[ax] >> shift);
  assign e_cur   = alu_res[63:30];
  assign neg_cur = n_neg[ax] ^ drneg;
  assign is_comp = (state >= S_SQ) && (state <= S_E1B);
  assign any_sat = pos_sat(pa[0]) || pos_sat(pa[1]) || pos_sat(pa[2]) ||
                   pos_sat(pb[0]) || pos_sat(pb[1]) || pos_sat(pb[2]);

  // Operands for the shared unit
  always_comb begin
    alu_cmd.start = is_comp && !issued;
    alu_cmd.op    = ALU_MUL;
    alu_a         = '0;
    alu_b         = '0;
    unique case (state)
      S_SQ: begin
        alu_a = 64'(h_cur);
        alu_b = 64'(h_cur);
      end
      S_SQRT: begin
        alu_cmd.op = ALU_SQRT;
        alu_a      = sum;
      end
      S_TS: begin
        alu_a = 64'(ts_eff);
        alu_b = 64'(ts_eff);
      end
      S_ALPHA: begin
        alu_cmd.op = ALU_DIV;
        alu_a      = {rq.compliance, 32'd0};
        alu_b      = 64'(ts2);
      end
      S_F0: begin
        alu_cmd.op = ALU_DIV;
        alu_a      = {2'd0, w0, 30'd0};
        alu_b      = den;
      end
      S_F1: begin
        alu_cmd.op = ALU_DIV;
        alu_a      = {2'd0, w1, 30'd0};
        alu_b      = den;
      end
      S_U: begin
        alu_cmd.op = ALU_DIV;
        alu_a      = {1'b0, nm[ax], 30'd0};
        alu_b      = 64'(d);
      end
      S_E0A: begin
        alu_a = 64'(drm);
        alu_b = 64'(f0);
      end
      S_E1A: begin
        alu_a = 64'(drm);
        alu_b = 64'(f1);
      end
      S_E0B, S_E1B: begin
        alu_a = 64'(t);
        alu_b = 64'(u);
      end
      default: begin
        alu_a = '0;
      end
    endcase
  end

  xdp_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .cmd    (alu_cmd),
    .opa    (alu_a),
    .opb    (alu_b),
    .done   (alu_done),
    .result (alu_res)
  );

  // Particle memories
  assign mem_addr = (state == S_RDB || state == S_WB) ? ib : ia;
  assign we_pos   = (state == S_WR) || (state == S_WA) || (state == S_WB);
  assign we_im    = (state == S_WR);

  always_comb begin
    if (state == S_WR) begin
      wr_x = rq.pos_x;
      wr_y = rq.pos_y;
      wr_z = rq.pos_z;
    end else if (state == S_WA) begin
      wr_x = clamp_pos(pa[0]);
      wr_y = clamp_pos(pa[1]);
      wr_z = clamp_pos(pa[2]);
    end else begin
      wr_x = clamp_pos(pb[0]);
      wr_y = clamp_pos(pb[1]);
      wr_z = clamp_pos(pb[2]);
    end
  end

  xdp_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_mem_x (
    .clk(clk), .we(we_pos), .addr(mem_addr), .wdata(wr_x), .rdata(rd_x)
  );
  xdp_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_mem_y (
    .clk(clk), .we(we_pos), .addr(mem_addr), .wdata(wr_y), .rdata(rd_y)
  );
  xdp_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_mem_z (
    .clk(clk), .we(we_pos), .addr(mem_addr), .wdata(wr_z), .rdata(rd_z)
  );
  xdp_ram #(.WIDTH(32), .DEPTH(NUM_PARTICLES)) u_mem_im (
    .clk(clk), .we(we_im), .addr(mem_addr), .wdata(rq.inverse_mass), .rdata(rd_im)
  );

  assign in_stall = (state != S_IDLE);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      issued    <= 1'b0;
    end else begin
      // Drop a taken result unless a new one replaces it this cycle
      if (out_valid && !out_stall && state != S_OUT) begin
        out_valid <= 1'b0;
      end
      if (alu_cmd.start) begin
        issued <= 1'b1;
      end
      if (alu_done) begin
        issued <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            rq <= in_data;
            ia <= idx_mod(in_data.particle_a);
            ib <= idx_mod(in_data.particle_b);
            if (in_data.req_type == REQ_WRITE) begin
              state <= S_WR;
            end else if (in_data.req_type == REQ_PROJECT ||
                         in_data.req_type == REQ_READ) begin
              state <= S_RDA;
            end else begin
              res   <= '0;
              state <= S_OUT;
            end
          end
        end
        S_WR: begin
          res   <= '{rq.pos_x, rq.pos_y, rq.pos_z, rq.inverse_mass, ST_DONE};
          state <= S_OUT;
        end
        S_RDA: begin
          state <= S_RDB;
        end
        S_RDB: begin
          // Particle a data is on the read port now
          pa[0] <= 35'(signed'(rd_x));
          pa[1] <= 35'(signed'(rd_y));
          pa[2] <= 35'(signed'(rd_z));
          w0    <= rd_im;
          if (rq.req_type == REQ_READ) begin
            res   <= '{rd_x, rd_y, rd_z, rd_im, ST_DONE};
            state <= S_OUT;
          end else begin
            state <= S_RDW;
          end
        end
        S_RDW: begin
          pb[0] <= 35'(signed'(rd_x));
          pb[1] <= 35'(signed'(rd_y));
          pb[2] <= 35'(signed'(rd_z));
          w1    <= rd_im;
          state <= S_CHK;
        end
        S_CHK: begin
          // Skip when both ends are fixed
          if (ws == '0) begin
            res   <= '{pa[0][31:0], pa[1][31:0], pa[2][31:0], w0, ST_FIXED};
            state <= S_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              nm[i]    <= nm_c[i];
              n_neg[i] <= ndiff[i][34];
            end
            shift <= shift_c;
            sum   <= '0;
            ax    <= 2'd0;
            state <= S_SQ;
          end
        end
        S_SQ: begin
          if (alu_done) begin
            sum <= sum + alu_res;
            if (ax == 2'd2) begin
              ax    <= 2'd0;
              state <= S_SQRT;
            end else begin
              ax <= ax + 2'd1;
            end
          end
        end
        S_SQRT: begin
          if (alu_done) begin
            d <= 33'(alu_res[31:0]) << shift;
            if (alu_res[31:0] == '0) begin
              res   <= '{pa[0][31:0], pa[1][31:0], pa[2][31:0], w0, ST_COINCIDENT};
              state <= S_OUT;
            end else begin
              state <= S_TS;
            end
          end
        end
        S_TS: begin
          if (alu_done) begin
            ts2   <= alu_res[33:0];
            state <= S_ALPHA;
          end
        end
        S_ALPHA: begin
          if (alu_done) begin
            den   <= den_sum[64] ? '1 : den_sum[63:0];
            state <= S_F0;
          end
        end
        S_F0: begin
          if (alu_done) begin
            f0    <= alu_res[30:0];
            state <= S_F1;
          end
        end
        S_F1: begin
          if (alu_done) begin
            f1    <= alu_res[30:0];
            drneg <= d < 33'(rq.rest_length);
            drm   <= (d < 33'(rq.rest_length)) ? 33'(rq.rest_length) - d
                                                : d - 33'(rq.rest_length);
            state <= S_U;
          end
        end
        S_U: begin
          if (alu_done) begin
            u     <= (alu_res > 64'd1 << 30) ? 31'd1 << 30 : alu_res[30:0];
            state <= S_E0A;
          end
        end
        S_E0A: begin
          if (alu_done) begin
            t     <= alu_res[63:30];
            state <= S_E0B;
          end
        end
        S_E0B: begin
          if (alu_done) begin
            pa[ax] <= neg_cur ? pa[ax] - signed'({1'b0, e_cur})
                              : pa[ax] + signed'({1'b0, e_cur});
            state  <= S_E1A;
          end
        end
        S_E1A: begin
          if (alu_done) begin
            t     <= alu_res[63:30];
            state <= S_E1B;
          end
        end
        S_E1B: begin
          if (alu_done) begin
            pb[ax] <= neg_cur ? pb[ax] + signed'({1'b0, e_cur})
                              : pb[ax] - signed'({1'b0, e_cur});
            if (ax == 2'd2) begin
              state <= S_WA;
            end else begin
              ax    <= ax + 2'd1;
              state <= S_U;
            end
          end
        end
        S_WA: begin
          state <= S_WB;
        end
        S_WB: begin
          // Particle b lands last, so it wins when both ends alias
          if (ia == ib) begin
            res <= '{clamp_pos(pb[0]), clamp_pos(pb[1]), clamp_pos(pb[2]), w0,
                     any_sat ? ST_SAT : ST_DONE};
          end else begin
            res <= '{clamp_pos(pa[0]), clamp_pos(pa[1]), clamp_pos(pa[2]), w0,
                     any_sat ? ST_SAT : ST_DONE};
          end
          state <= S_OUT;
        end
        S_OUT: begin
          // Hold until the output register is free
          if (!out_valid || !out_stall) begin
            out_data  <= res;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // The shared unit only finishes work the sequencer started
  a_done_issued: assert property (@(posedge clk) disable iff (rst)
    alu_done |-> issued)
    else $error("shared unit finished without a pending operation");

  // An operation in flight never outlives its compute step
  a_issued_comp: assert property (@(posedge clk) disable iff (rst)
    issued |-> is_comp)
    else $error("shared unit busy outside a compute step");

  // Every accepted request starts work
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state != S_IDLE))
    else $error("accepted request left the sequencer idle");

endmodule
